// ===== rtl/spi_sensor_hub_transfer_sequencer_assert.svh =====
// Assertion macros for the SPI sensor hub transfer sequencer checker.
// No dependencies; included by the checker file.
`ifndef SPI_SENSOR_HUB_TRANSFER_SEQUENCER_ASSERT_SVH
`define SPI_SENSOR_HUB_TRANSFER_SEQUENCER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/shs_pkg.sv =====
// Shared types, constants and helper functions of the SPI sensor hub sequencer.
// No dependencies; used by shs_step and the top level.
package shs_pkg;

	localparam int RX_BUF_BYTES = 1024;
	localparam int TX_BUF_BYTES = 256;
	localparam int HDR_BYTES    = 4;

	localparam int LEN_W  = 11;   // rx counts and transfer lengths
	localparam int TXC_W  = 9;    // transmit count
	localparam int OFF_W  = 3;    // receive buffer offset
	localparam int PH_W   = 3;    // encoded phase

	localparam logic [15:0] LEN_CONT_MASK = 16'h8000;

	typedef enum logic [2:0] {
		REQ_POLL     = 3'd0,
		REQ_IRQ      = 3'd1,
		REQ_DONE     = 3'd2,
		REQ_QUEUE_TX = 3'd3,
		REQ_RX_TAKEN = 3'd4,
		REQ_RESET    = 3'd5
	} req_t;

	typedef enum logic [7:0] {
		PH_OFF       = 8'b0000_0001,
		PH_IDLE      = 8'b0000_0010,
		PH_HDR_WAIT  = 8'b0000_0100,
		PH_HDR_DONE  = 8'b0000_1000,
		PH_BODY_WAIT = 8'b0001_0000,
		PH_BODY_DONE = 8'b0010_0000,
		PH_WR_WAIT   = 8'b0100_0000,
		PH_WR_DONE   = 8'b1000_0000
	} phase_t;

	localparam logic [PH_W-1:0] PC_OFF       = 3'd0;
	localparam logic [PH_W-1:0] PC_IDLE      = 3'd1;
	localparam logic [PH_W-1:0] PC_HDR_WAIT  = 3'd2;
	localparam logic [PH_W-1:0] PC_HDR_DONE  = 3'd3;
	localparam logic [PH_W-1:0] PC_BODY_WAIT = 3'd4;
	localparam logic [PH_W-1:0] PC_BODY_DONE = 3'd5;
	localparam logic [PH_W-1:0] PC_WR_WAIT   = 3'd6;
	localparam logic [PH_W-1:0] PC_WR_DONE   = 3'd7;

	typedef struct packed {
		phase_t            phase;
		logic              irq_pending;
		logic [LEN_W-1:0]  rx_count;
		logic [TXC_W-1:0]  tx_count;
		logic              select_on;
	} seq_state_t;

	typedef struct packed {
		logic              cs_active;
		logic              start_xfer;
		logic              xfer_source;
		logic [OFF_W-1:0]  xfer_offset;
		logic [LEN_W-1:0]  xfer_len;
		logic              wake_release;
		logic [LEN_W-1:0]  rx_avail;
		logic [PH_W-1:0]   phase;
	} result_t;

	function automatic logic [PH_W-1:0] phase_code(input phase_t ph);
		logic [PH_W-1:0] code;
		unique case (ph)
			PH_OFF:       code = PC_OFF;
			PH_IDLE:      code = PC_IDLE;
			PH_HDR_WAIT:  code = PC_HDR_WAIT;
			PH_HDR_DONE:  code = PC_HDR_DONE;
			PH_BODY_WAIT: code = PC_BODY_WAIT;
			PH_BODY_DONE: code = PC_BODY_DONE;
			PH_WR_WAIT:   code = PC_WR_WAIT;
			PH_WR_DONE:   code = PC_WR_DONE;
			default:      code = PC_OFF;
		endcase
		return code;
	endfunction

	// Packet length from the header: drop the continuation bit, clamp to the buffer.
	function automatic logic [LEN_W-1:0] header_len(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] raw;
		raw = {hi, lo} & ~LEN_CONT_MASK;
		if (raw > 16'(RX_BUF_BYTES))
			return LEN_W'(RX_BUF_BYTES);
		return raw[LEN_W-1:0];
	endfunction

endpackage

// ===== rtl/shs_step.sv =====
// Next-state and result logic for one event of the transfer sequencer.
// Depends on shs_pkg.
module shs_step (
	input  logic [2:0]          req_type,
	input  logic [7:0]          hdr_low,
	input  logic [7:0]          hdr_high,
	input  logic [8:0]          tx_len,
	input  shs_pkg::seq_state_t cur,
	output shs_pkg::seq_state_t nxt,
	output shs_pkg::result_t    res
);
	import shs_pkg::*;

	logic [LEN_W-1:0] hlen;
	logic [LEN_W-1:0] tx_ext;
	logic [TXC_W-1:0] tx_clamped;
	logic             act_write;

	assign hlen       = header_len(hdr_low, hdr_high);
	assign tx_ext     = LEN_W'(cur.tx_count);
	assign tx_clamped = (tx_len > 9'(TX_BUF_BYTES)) ? TXC_W'(TX_BUF_BYTES) : tx_len;
	assign act_write  = (cur.tx_count != '0);

	always_comb begin
		logic launch;
		logic activate;
		launch   = 1'b0;
		activate = 1'b0;
		nxt = cur;
		res = '0;

		if (req_t'(req_type) == REQ_RESET) begin
			nxt.phase       = PH_IDLE;
			nxt.irq_pending = 1'b0;
			nxt.rx_count    = '0;
			nxt.tx_count    = '0;
			nxt.select_on   = 1'b0;
		end else if (cur.phase != PH_OFF) begin
			unique case (req_t'(req_type))
				REQ_POLL: begin
					unique case (cur.phase)
						PH_IDLE: begin
							activate = cur.irq_pending && (cur.rx_count == '0);
						end
						PH_HDR_DONE: begin
							if (hlen > LEN_W'(HDR_BYTES)) begin
								nxt.phase       = PH_BODY_WAIT;
								launch          = 1'b1;
								res.xfer_offset = OFF_W'(HDR_BYTES);
								res.xfer_len    = hlen - LEN_W'(HDR_BYTES);
							end else begin
								// short header: release, then retry a launch at once
								nxt.select_on = 1'b0;
								nxt.rx_count  = '0;
								nxt.phase     = PH_IDLE;
								activate      = cur.irq_pending;
							end
						end
						PH_BODY_DONE: begin
							nxt.select_on = 1'b0;
							nxt.rx_count  = hlen;
							nxt.phase     = PH_IDLE;
						end
						PH_WR_DONE: begin
							nxt.select_on = 1'b0;
							nxt.rx_count  = (tx_ext < hlen) ? tx_ext : hlen;
							nxt.tx_count  = '0;
							nxt.phase     = PH_IDLE;
						end
						default: ;
					endcase
				end
				REQ_IRQ: nxt.irq_pending = 1'b1;
				REQ_DONE: begin
					unique case (cur.phase)
						PH_HDR_WAIT:  nxt.phase = PH_HDR_DONE;
						PH_BODY_WAIT: nxt.phase = PH_BODY_DONE;
						PH_WR_WAIT:   nxt.phase = PH_WR_DONE;
						default: ;
					endcase
				end
				REQ_QUEUE_TX: begin
					if (cur.phase != PH_WR_WAIT && cur.phase != PH_WR_DONE)
						nxt.tx_count = tx_clamped;
				end
				REQ_RX_TAKEN: nxt.rx_count = '0;
				default: ;
			endcase
		end

		if (activate) begin
			nxt.irq_pending = 1'b0;
			nxt.select_on   = 1'b1;
			launch          = 1'b1;
			res.xfer_offset = '0;
			if (act_write) begin
				nxt.phase        = PH_WR_WAIT;
				res.xfer_source  = 1'b1;
				res.xfer_len     = tx_ext;
				res.wake_release = 1'b1;
			end else begin
				nxt.phase    = PH_HDR_WAIT;
				res.xfer_len = LEN_W'(HDR_BYTES);
			end
		end

		res.start_xfer = launch;
		res.cs_active  = nxt.select_on;
		res.rx_avail   = nxt.rx_count;
		res.phase      = phase_code(nxt.phase);
	end

endmodule

// ===== rtl/spi_sensor_hub_transfer_sequencer.sv =====
// Top level of the SPI sensor hub transfer sequencer: input register, state, result register.
// Depends on shs_pkg and shs_step.
//
// Host-side sequencer for a length-prefixed packet protocol carried over SPI. Each
// input transfer is one event (poll, device interrupt, transfer done, queue transmit,
// rx consumed, reset/start) and yields exactly one result transfer describing chip
// select, any SPI transfer launched by that event, the bytes available to the
// consumer and the new phase. The block starts in the off phase and ignores every
// event until a reset/start event. Throughput is one event per clock while the output
// side is ready: the input register, the combinational step logic and the result
// register form a two-stage pipe, so an accepted event is held in the input register
// and its result is then captured in the result register once that register is free
// or drains. The sequencer state updates in the same cycle an event moves from the
// input register into the result register, so events are processed strictly in order.
// A stalled result holds in the result register while the input register may still
// take one more event.
module spi_sensor_hub_transfer_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  hdr_low,
	input  logic [7:0]  hdr_high,
	input  logic [8:0]  tx_len,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cs_active,
	output logic        start_xfer,
	output logic        xfer_source,
	output logic [2:0]  xfer_offset,
	output logic [10:0] xfer_len,
	output logic        wake_release,
	output logic [10:0] rx_avail,
	output logic [2:0]  phase
);
	import shs_pkg::*;

	// input stage
	logic        valid_s1;
	logic [2:0]  req_s1;
	logic [7:0]  hdr_low_s1;
	logic [7:0]  hdr_high_s1;
	logic [8:0]  tx_len_s1;

	// sequencer state and result register
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	result_t     res_nxt;
	result_t     res_s2;
	logic        valid_s2;

	logic        advance;
	logic        in_take;

	// Move an event into the result register whenever that register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the event payload on each accepted transfer.
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1      <= req_type;
			hdr_low_s1  <= hdr_low;
			hdr_high_s1 <= hdr_high;
			tx_len_s1   <= tx_len;
		end
	end

	shs_step u_step (
		.req_type (req_s1),
		.hdr_low  (hdr_low_s1),
		.hdr_high (hdr_high_s1),
		.tx_len   (tx_len_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// Commit the state only when the event's result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_OFF;
			state_q.irq_pending <= 1'b0;
			state_q.rx_count    <= '0;
			state_q.tx_count    <= '0;
			state_q.select_on   <= 1'b0;
			valid_s2            <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// Hold the result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid    = valid_s2;
	assign cs_active    = res_s2.cs_active;
	assign start_xfer   = res_s2.start_xfer;
	assign xfer_source  = res_s2.xfer_source;
	assign xfer_offset  = res_s2.xfer_offset;
	assign xfer_len     = res_s2.xfer_len;
	assign wake_release = res_s2.wake_release;
	assign rx_avail     = res_s2.rx_avail;
	assign phase        = res_s2.phase;

endmodule

// ===== rtl/shs_checker.sv =====
// Port-level checker for the SPI sensor hub transfer sequencer, bound to the top level.
// Depends on shs_pkg-free port view and spi_sensor_hub_transfer_sequencer_assert.svh.
`include "spi_sensor_hub_transfer_sequencer_assert.svh"

module shs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  req_type,
	input logic [7:0]  hdr_low,
	input logic [7:0]  hdr_high,
	input logic [8:0]  tx_len,
	input logic        out_valid,
	input logic        out_ready,
	input logic        cs_active,
	input logic        start_xfer,
	input logic        xfer_source,
	input logic [2:0]  xfer_offset,
	input logic [10:0] xfer_len,
	input logic        wake_release,
	input logic [10:0] rx_avail,
	input logic [2:0]  phase
);

	// A stalled result holds.
	`SHS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({cs_active, start_xfer, xfer_source, xfer_offset, xfer_len, wake_release, rx_avail, phase}), "result changed while stalled")

	// A launched transfer always runs with chip select asserted.
	`SHS_ASSERT_IMPL(a_launch_cs, clk, arst_n, out_valid && start_xfer, cs_active, "transfer launched without chip select")

	// Wake release only comes with a write launch.
	`SHS_ASSERT_IMPL(a_wake_write, clk, arst_n, out_valid && wake_release, start_xfer && xfer_source && (xfer_offset == 3'd0), "wake released without a write launch")

	// Without a launch the transfer fields are clear.
	`SHS_ASSERT_IMPL(a_idle_fields, clk, arst_n, out_valid && !start_xfer, !xfer_source && !wake_release && (xfer_offset == 3'd0) && (xfer_len == 11'd0), "transfer fields set without a launch")

	// In the off phase nothing is selected or available.
	`SHS_ASSERT_IMPL(a_off_quiet, clk, arst_n, out_valid && (phase == 3'd0), !cs_active && (rx_avail == 11'd0) && !start_xfer, "activity reported in off phase")

endmodule

bind spi_sensor_hub_transfer_sequencer shs_checker u_shs_checker (.*);
